/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the control core.
// Each macro states one concurrent property, clocked on the rising edge
// and switched off while the active-low reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hct_pkg.sv */
package hct_pkg;

    // Field widths of the channels and registers.
    localparam int CMD_W      = 3;
    localparam int TEMP_W     = 8;
    localparam int SETPOINT_W = 7;
    localparam int STEP_W     = 5;
    localparam int BAND_W     = 6;
    localparam int TICKS_W    = 16;
    localparam int DISPLAY_W  = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register values after reset.
    localparam logic [SETPOINT_W-1:0] SETPOINT_MIN_RST     = 7'd35;
    localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RST     = 7'd75;
    localparam logic [STEP_W-1:0]     SETPOINT_STEP_RST    = 5'd5;
    localparam logic [BAND_W-1:0]     HYSTERESIS_BAND_RST  = 6'd5;
    localparam logic [TICKS_W-1:0]    EDIT_WINDOW_RST      = 16'd152;
    localparam logic [TICKS_W-1:0]    BLINK_TICKS_RST      = 16'd30;
    localparam logic [SETPOINT_W-1:0] INITIAL_SETPOINT_RST = 7'd60;

    // Event codes on the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_UP     = 3'd1,
        CMD_DOWN   = 3'd2,
        CMD_POWER  = 3'd3,
        CMD_SAMPLE = 3'd4
    } t_cmd;

    // Register indexes on the configuration port.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SETPOINT_MIN     = 3'd0,
        REG_SETPOINT_MAX     = 3'd1,
        REG_SETPOINT_STEP    = 3'd2,
        REG_HYSTERESIS_BAND  = 3'd3,
        REG_EDIT_WINDOW      = 3'd4,
        REG_BLINK_TICKS      = 3'd5,
        REG_INITIAL_SETPOINT = 3'd6
    } t_reg_idx;

    // Settings the control core works from.
    typedef struct packed {
        logic [SETPOINT_W-1:0] setpoint_min;
        logic [SETPOINT_W-1:0] setpoint_max;
        logic [STEP_W-1:0]     setpoint_step;
        logic [BAND_W-1:0]     hysteresis_band;
        logic [TICKS_W-1:0]    edit_window_ticks;
        logic [TICKS_W-1:0]    blink_ticks;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic                  power_on;
        logic                  heater_on;
        logic                  cooler_on;
        logic                  heater_led;
        logic                  cooler_led;
        logic [DISPLAY_W-1:0]  display_value;
        logic                  save_strobe;
        logic [SETPOINT_W-1:0] save_value;
    } t_result;

endpackage

/* hw/rtl/hct_in_if.sv */
interface hct_in_if;

    logic                     valid;
    logic                     ready;
    logic [hct_pkg::CMD_W-1:0]  command;
    logic [hct_pkg::TEMP_W-1:0] temperature;

    modport source (output valid, output command, output temperature, input ready);
    modport sink (input valid, input command, input temperature, output ready);

endinterface

/* hw/rtl/hct_out_if.sv */
interface hct_out_if;

    logic                         valid;
    logic                         ready;
    logic                         power_on;
    logic                         heater_on;
    logic                         cooler_on;
    logic                         heater_led;
    logic                         cooler_led;
    logic [hct_pkg::DISPLAY_W-1:0]  display_value;
    logic                         save_strobe;
    logic [hct_pkg::SETPOINT_W-1:0] save_value;

    modport source (
        output valid, output power_on, output heater_on, output cooler_on,
        output heater_led, output cooler_led, output display_value,
        output save_strobe, output save_value, input ready
    );
    modport sink (
        input valid, input power_on, input heater_on, input cooler_on,
        input heater_led, input cooler_led, input display_value,
        input save_strobe, input save_value, output ready
    );

endinterface

/* hw/rtl/hct_core.sv */
`include "assert_macros.svh"

module hct_core #(
    parameter int AVERAGE_DEPTH = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hct_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hct_pkg::CMD_W-1:0]   i_command,
    input  logic [hct_pkg::TEMP_W-1:0]  i_temperature,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hct_pkg::t_result            o_result
);

    localparam int IDX_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SUM_W = $clog2(255 * AVERAGE_DEPTH + 1);
    localparam int CMP_W = $clog2(AVERAGE_DEPTH) + 10;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVERAGE_DEPTH - 1);
    localparam logic signed [CMP_W-1:0] DEPTH_S = CMP_W'(AVERAGE_DEPTH);

    // Input register.
    logic                        r_in_valid;
    logic [hct_pkg::CMD_W-1:0]   r_cmd;
    logic [hct_pkg::TEMP_W-1:0]  r_temp;

    // Controller state.
    logic                           r_power;
    logic [hct_pkg::SETPOINT_W-1:0] r_setpoint;
    logic [hct_pkg::TICKS_W-1:0]    r_edit;
    logic [hct_pkg::TICKS_W-1:0]    r_blink;
    logic [hct_pkg::TEMP_W-1:0]     r_ring [AVERAGE_DEPTH];
    logic [SUM_W-1:0]               r_sum;
    logic [IDX_W-1:0]               r_ring_idx;
    logic                           r_primed;
    logic [hct_pkg::TEMP_W-1:0]     r_last_temperature;
    logic                           r_heater;
    logic                           r_cooler;
    logic                           r_heater_led;
    logic                           r_cooler_led;

    // Result register.
    logic             r_out_valid;
    hct_pkg::t_result r_result;

    logic                           n_power;
    logic [hct_pkg::SETPOINT_W-1:0] n_setpoint;
    logic [hct_pkg::TICKS_W-1:0]    n_edit;
    logic [hct_pkg::TICKS_W-1:0]    n_blink;
    logic [SUM_W-1:0]               n_sum;
    logic [IDX_W-1:0]               n_ring_idx;
    logic                           n_primed;
    logic [hct_pkg::TEMP_W-1:0]     n_last_temperature;
    logic                           n_heater;
    logic                           n_cooler;
    logic                           n_heater_led;
    logic                           n_cooler_led;
    hct_pkg::t_result               n_result;

    logic w_advance;
    logic w_take_sample;
    logic w_strobe;

    // The item in the input register moves on when the result register is free.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Next state and result for the item in the input register.
    always_comb begin
        logic [hct_pkg::SETPOINT_W:0] up_sum;
        logic [hct_pkg::SETPOINT_W:0] down_floor;
        logic signed [CMP_W-1:0]      sum_s;
        logic signed [CMP_W-1:0]      sp_s;
        logic signed [CMP_W-1:0]      band_s;
        logic signed [CMP_W-1:0]      lo_bound;
        logic signed [CMP_W-1:0]      hi_bound;

        n_power            = r_power;
        n_setpoint         = r_setpoint;
        n_edit             = r_edit;
        n_blink            = r_blink;
        n_sum              = r_sum;
        n_ring_idx         = r_ring_idx;
        n_primed           = r_primed;
        n_last_temperature = r_last_temperature;
        n_heater           = r_heater;
        n_cooler           = r_cooler;
        n_heater_led       = r_heater_led;
        n_cooler_led       = r_cooler_led;
        w_strobe           = 1'b0;
        w_take_sample      = 1'b0;

        up_sum     = {1'b0, r_setpoint} + (hct_pkg::SETPOINT_W + 1)'(i_cfg.setpoint_step);
        down_floor = {1'b0, i_cfg.setpoint_min}
                   + (hct_pkg::SETPOINT_W + 1)'(i_cfg.setpoint_step);

        // The event itself.
        if (r_cmd == hct_pkg::CMD_POWER) begin
            n_power = !r_power;
            if (r_power) begin
                n_heater     = 1'b0;
                n_cooler     = 1'b0;
                n_heater_led = 1'b0;
                n_cooler_led = 1'b0;
            end
        end else if (r_power) begin
            unique case (r_cmd)
                hct_pkg::CMD_TICK: begin
                    if (r_blink != '0) begin
                        n_blink = r_blink - 1'b1;
                    end
                    if (r_edit != '0) begin
                        n_edit   = r_edit - 1'b1;
                        w_strobe = (r_edit == hct_pkg::TICKS_W'(1));
                    end
                end
                hct_pkg::CMD_UP: begin
                    if (r_setpoint < i_cfg.setpoint_max && r_edit != '0) begin
                        n_setpoint = (up_sum > {1'b0, i_cfg.setpoint_max}) ?
                                     i_cfg.setpoint_max : up_sum[hct_pkg::SETPOINT_W-1:0];
                    end
                    n_edit = i_cfg.edit_window_ticks;
                end
                hct_pkg::CMD_DOWN: begin
                    if (r_setpoint > i_cfg.setpoint_min && r_edit != '0) begin
                        n_setpoint = ({1'b0, r_setpoint} >= down_floor) ?
                                     r_setpoint - hct_pkg::SETPOINT_W'(i_cfg.setpoint_step) :
                                     i_cfg.setpoint_min;
                    end
                    n_edit = i_cfg.edit_window_ticks;
                end
                hct_pkg::CMD_SAMPLE: begin
                    w_take_sample      = 1'b1;
                    n_last_temperature = r_temp;
                    n_primed           = 1'b1;
                    if (!r_primed) begin
                        n_sum = SUM_W'(AVERAGE_DEPTH) * SUM_W'(r_temp);
                    end else begin
                        n_sum = r_sum - SUM_W'(r_ring[r_ring_idx]) + SUM_W'(r_temp);
                    end
                    if (!r_primed || r_ring_idx == LAST_IDX) begin
                        n_ring_idx = r_primed ? '0 : IDX_W'(1 % AVERAGE_DEPTH);
                    end else begin
                        n_ring_idx = r_ring_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Hysteresis on the average, compared as sum against depth times bound.
        sum_s    = CMP_W'(n_sum);
        sp_s     = CMP_W'(n_setpoint);
        band_s   = CMP_W'(i_cfg.hysteresis_band);
        lo_bound = DEPTH_S * (sp_s - band_s);
        hi_bound = DEPTH_S * (sp_s + band_s + CMP_W'(1));
        if (n_power && n_primed) begin
            priority if (sum_s < lo_bound) begin
                if (!n_heater) begin
                    n_heater     = 1'b1;
                    n_cooler     = 1'b0;
                    n_cooler_led = 1'b0;
                end
            end else if (sum_s >= hi_bound) begin
                if (!n_cooler) begin
                    n_heater     = 1'b0;
                    n_cooler     = 1'b1;
                    n_heater_led = 1'b0;
                end
            end else begin
                // Inside the band the relays keep their state.
            end
        end

        // Blink of the active LED, using the relay states just decided.
        if (n_power) begin
            priority if (n_blink == '0 && n_cooler) begin
                n_blink      = i_cfg.blink_ticks;
                n_cooler_led = !n_cooler_led;
            end else if (n_blink == '0 && n_heater) begin
                n_blink      = i_cfg.blink_ticks;
                n_heater_led = !n_heater_led;
            end else begin
                // No toggle due, or no relay active.
            end
        end

        // Result fields; all zero while off.
        n_result = '0;
        if (n_power) begin
            n_result.power_on      = 1'b1;
            n_result.heater_on     = n_heater;
            n_result.cooler_on     = n_cooler;
            n_result.heater_led    = n_heater_led;
            n_result.cooler_led    = n_cooler_led;
            n_result.display_value = (n_edit != '0) ?
                                     hct_pkg::DISPLAY_W'(n_setpoint) : n_last_temperature;
            n_result.save_strobe   = w_strobe;
            n_result.save_value    = w_strobe ? n_setpoint : '0;
        end
    end

    // Control state, input register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_power            <= 1'b0;
            r_setpoint         <= hct_pkg::INITIAL_SETPOINT_RST;
            r_edit             <= '0;
            r_blink            <= hct_pkg::BLINK_TICKS_RST;
            r_ring_idx         <= '0;
            r_primed           <= 1'b0;
            r_last_temperature <= '0;
            r_heater           <= 1'b0;
            r_cooler           <= 1'b0;
            r_heater_led       <= 1'b0;
            r_cooler_led       <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid        <= 1'b1;
                r_power            <= n_power;
                r_setpoint         <= n_setpoint;
                r_edit             <= n_edit;
                r_blink            <= n_blink;
                r_ring_idx         <= n_ring_idx;
                r_primed           <= n_primed;
                r_last_temperature <= n_last_temperature;
                r_heater           <= n_heater;
                r_cooler           <= n_cooler;
                r_heater_led       <= n_heater_led;
                r_cooler_led       <= n_cooler_led;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: input item, sample ring, running sum, result.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_command;
            r_temp <= i_temperature;
        end
        if (w_advance) begin
            r_result <= n_result;
            r_sum    <= n_sum;
            if (w_take_sample) begin
                if (!r_primed) begin
                    for (int i = 0; i < AVERAGE_DEPTH; i++) begin
                        r_ring[i] <= r_temp;
                    end
                end else begin
                    r_ring[r_ring_idx] <= r_temp;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // Checks on the control logic.
    `ASSERT_IMPLY(a_relay_excl, i_clk, i_rst_n, r_out_valid,
        !(r_result.heater_on && r_result.cooler_on), "heater and cooler both driven")
    `ASSERT_IMPLY(a_off_quiet, i_clk, i_rst_n, r_out_valid && !r_result.power_on,
        r_result.display_value == '0 && !r_result.save_strobe && !r_result.heater_on
        && !r_result.cooler_on, "result not cleared while off")
    `ASSERT_NEXT(a_advance_result, i_clk, i_rst_n, w_advance, r_out_valid,
        "transfer into result register lost")
    `ASSERT_IMPLY(a_ring_idx_range, i_clk, i_rst_n, 1'b1, r_ring_idx <= LAST_IDX,
        "ring index beyond depth")
    `ASSERT_IMPLY(a_strobe_display, i_clk, i_rst_n, r_out_valid && r_result.save_strobe,
        r_result.display_value == r_last_temperature, "window closed but setpoint shown")

endmodule

/* hw/rtl/heater_cooler_thermostat.sv */
// Heater/cooler thermostat with hysteresis.
// Input channel i_in carries one event per transfer: a tick, an up or down
// press, a power press or a temperature sample. Output channel o_out returns
// exactly one result per event: relay and LED drives, the display value and
// a save request with the setpoint to store when the edit window closes.
// Both channels use valid/ready; a transfer happens when both are high.
// Settings are written over the APB port (byte address 4 * register index)
// and read back from prdata; the user must write them only while no event is
// in flight, which the block itself does not enforce. An event passes through
// the input register, then the result register. Throughput is one event per
// cycle while the receiver takes results, set by the combinational update of
// the controller state between them; the moving average is a running sum.
// When the receiver stalls, the result register holds and one more event is
// held in the input register, after which i_in.ready drops.
// Reset (synchronous, active low) switches the controller off, loads the
// settings with their defaults and the setpoint with the default initial setpoint,
// and empties the sample ring; the first sample after that fills it.
module heater_cooler_thermostat #(
    parameter int AVERAGE_DEPTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hct_in_if.sink                          i_in,
    hct_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hct_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [hct_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [hct_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [hct_pkg::SETPOINT_W-1:0] r_setpoint_min;
    logic [hct_pkg::SETPOINT_W-1:0] r_setpoint_max;
    logic [hct_pkg::STEP_W-1:0]     r_setpoint_step;
    logic [hct_pkg::BAND_W-1:0]     r_hysteresis_band;
    logic [hct_pkg::TICKS_W-1:0]    r_edit_window_ticks;
    logic [hct_pkg::TICKS_W-1:0]    r_blink_ticks;
    logic [hct_pkg::SETPOINT_W-1:0] r_initial_setpoint;

    logic                             w_cfg_write;
    logic [hct_pkg::REG_IDX_W-1:0]    w_reg_idx;
    hct_pkg::t_cfg                    w_cfg;
    hct_pkg::t_result                 w_result;

    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[hct_pkg::APB_ADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite;

    // Setting registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint_min      <= hct_pkg::SETPOINT_MIN_RST;
            r_setpoint_max      <= hct_pkg::SETPOINT_MAX_RST;
            r_setpoint_step     <= hct_pkg::SETPOINT_STEP_RST;
            r_hysteresis_band   <= hct_pkg::HYSTERESIS_BAND_RST;
            r_edit_window_ticks <= hct_pkg::EDIT_WINDOW_RST;
            r_blink_ticks       <= hct_pkg::BLINK_TICKS_RST;
            r_initial_setpoint  <= hct_pkg::INITIAL_SETPOINT_RST;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                hct_pkg::REG_SETPOINT_MIN:
                    r_setpoint_min <= pwdata[hct_pkg::SETPOINT_W-1:0];
                hct_pkg::REG_SETPOINT_MAX:
                    r_setpoint_max <= pwdata[hct_pkg::SETPOINT_W-1:0];
                hct_pkg::REG_SETPOINT_STEP:
                    r_setpoint_step <= pwdata[hct_pkg::STEP_W-1:0];
                hct_pkg::REG_HYSTERESIS_BAND:
                    r_hysteresis_band <= pwdata[hct_pkg::BAND_W-1:0];
                hct_pkg::REG_EDIT_WINDOW:
                    r_edit_window_ticks <= pwdata[hct_pkg::TICKS_W-1:0];
                hct_pkg::REG_BLINK_TICKS:
                    r_blink_ticks <= pwdata[hct_pkg::TICKS_W-1:0];
                hct_pkg::REG_INITIAL_SETPOINT:
                    r_initial_setpoint <= pwdata[hct_pkg::SETPOINT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            hct_pkg::REG_SETPOINT_MIN:     prdata = hct_pkg::APB_DATA_W'(r_setpoint_min);
            hct_pkg::REG_SETPOINT_MAX:     prdata = hct_pkg::APB_DATA_W'(r_setpoint_max);
            hct_pkg::REG_SETPOINT_STEP:    prdata = hct_pkg::APB_DATA_W'(r_setpoint_step);
            hct_pkg::REG_HYSTERESIS_BAND:  prdata = hct_pkg::APB_DATA_W'(r_hysteresis_band);
            hct_pkg::REG_EDIT_WINDOW:      prdata = hct_pkg::APB_DATA_W'(r_edit_window_ticks);
            hct_pkg::REG_BLINK_TICKS:      prdata = hct_pkg::APB_DATA_W'(r_blink_ticks);
            hct_pkg::REG_INITIAL_SETPOINT: prdata = hct_pkg::APB_DATA_W'(r_initial_setpoint);
            default:                       prdata = '0;
        endcase
    end

    // Settings handed to the control core.
    always_comb begin
        w_cfg.setpoint_min      = r_setpoint_min;
        w_cfg.setpoint_max      = r_setpoint_max;
        w_cfg.setpoint_step     = r_setpoint_step;
        w_cfg.hysteresis_band   = r_hysteresis_band;
        w_cfg.edit_window_ticks = r_edit_window_ticks;
        w_cfg.blink_ticks       = r_blink_ticks;
    end

    hct_core #(
        .AVERAGE_DEPTH(AVERAGE_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in.valid),
        .o_in_ready   (i_in.ready),
        .i_command    (i_in.command),
        .i_temperature(i_in.temperature),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_result     (w_result)
    );

    // Result fields onto the output channel.
    assign o_out.power_on      = w_result.power_on;
    assign o_out.heater_on     = w_result.heater_on;
    assign o_out.cooler_on     = w_result.cooler_on;
    assign o_out.heater_led    = w_result.heater_led;
    assign o_out.cooler_led    = w_result.cooler_led;
    assign o_out.display_value = w_result.display_value;
    assign o_out.save_strobe   = w_result.save_strobe;
    assign o_out.save_value    = w_result.save_value;

endmodule
